// ===== src/pidfd_pkg.sv =====
package pidfd_pkg;

	localparam logic [15:0] MAX_STEP_US = 16'd20000;
	localparam logic [19:0] USEC_PER_S  = 20'd1000000;
	localparam logic [19:0] FILT_DEN    = 20'd10;

	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd53;

	localparam logic [2:0] REG_GAIN_P         = 3'd0;
	localparam logic [2:0] REG_GAIN_I         = 3'd1;
	localparam logic [2:0] REG_GAIN_D         = 3'd2;
	localparam logic [2:0] REG_INTEGRAL_BOUND = 3'd3;
	localparam logic [2:0] REG_DRIVE_BOUND    = 3'd4;

	localparam logic signed [39:0] DERIV_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] DERIV_MIN = {1'b1, {39{1'b0}}};

	typedef logic signed [57:0] sum_t;

endpackage

// ===== src/pid_filtered_derivative_antiwindup_unit.sv =====
// PID controller in signed Q15.16 with a low-pass filtered derivative (weight 3/10) and
// conditional-integration anti-windup; the output is clamped to +-drive_bound and flagged
// when clamped. One word is in flight at a time. All products and quotients run through
// one bit-serial shift-add multiplier and one restoring divider. A regular item forms
// the derivative, filter and integral terms, then the P, D and I products; the first
// item after reset or a register write skips the derivative and filter, a rejected
// integral update adds one more product, and a zero time step goes straight to output.
// The result sits in an output register; a new word is taken once the sequence is back
// to idle. Writing any of the five registers clears integral, previous error and filter.
module pid_filtered_derivative_antiwindup_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measured,
	input  logic [15:0] step_us,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [31:0] drive,
	output logic        saturated
);
	import pidfd_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DMUL = 4'd1;
	localparam logic [3:0] S_RDIV = 4'd2;
	localparam logic [3:0] S_FDIV = 4'd3;
	localparam logic [3:0] S_IMUL = 4'd4;
	localparam logic [3:0] S_IDIV = 4'd5;
	localparam logic [3:0] S_PMUL = 4'd6;
	localparam logic [3:0] S_GMUL = 4'd7;
	localparam logic [3:0] S_CMUL = 4'd8;
	localparam logic [3:0] S_OMUL = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q;
	logic [5:0] cnt_q;
	logic       primed_q;
	logic       rv_q;

	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] ibound_q, dbound_q;

	logic signed [31:0] ia_q;
	logic signed [32:0] le_q;
	logic signed [39:0] d_q;

	logic signed [32:0] e_q;
	logic [15:0] dt_q;
	logic signed [31:0] cand_q;
	sum_t spd_q, sum_q;
	logic sg_q;
	logic signed [31:0] drive_q;
	logic sat_q;

	logic [31:0] ma_q;
	logic [39:0] mb_q;
	logic [40:0] hi_q;
	logic [53:0] dq_q;
	logic [19:0] rem_q;
	logic [19:0] dv_q;

	logic cfg_wr;
	logic [2:0] cfg_idx;
	logic cfg_hit;

	logic signed [32:0] err;
	logic signed [33:0] diff;
	logic [32:0] diff_mag;
	logic [15:0] dt_cap;
	logic [32:0] e_mag;

	logic [40:0] mul_add;
	logic [72:0] prod;
	logic [55:0] term_mag;
	sum_t term;

	logic [20:0] trial;
	logic ge;
	logic [19:0] rem_n;
	logic [53:0] quo;

	logic signed [39:0] raw;
	logic signed [40:0] flt_x;
	logic signed [42:0] flt_y;
	logic [41:0] flt_mag;
	logic signed [39:0] flt_step;

	logic signed [29:0] incr;
	logic signed [33:0] csum;
	logic signed [33:0] ib_ext;
	logic signed [31:0] cand;

	logic [31:0] gp_mag, gi_mag, gd_mag;
	logic [39:0] d_mag;
	logic [31:0] cand_mag, ia_mag;

	sum_t db_ext, sc;
	logic accept;
	logic e_pos;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];
	assign cfg_hit = cfg_idx == REG_GAIN_P || cfg_idx == REG_GAIN_I || cfg_idx == REG_GAIN_D
		|| cfg_idx == REG_INTEGRAL_BOUND || cfg_idx == REG_DRIVE_BOUND;

	always_comb begin
		unique case (cfg_idx)
			REG_GAIN_P:         prdata = gain_p_q;
			REG_GAIN_I:         prdata = gain_i_q;
			REG_GAIN_D:         prdata = gain_d_q;
			REG_INTEGRAL_BOUND: prdata = {1'b0, ibound_q};
			REG_DRIVE_BOUND:    prdata = {1'b0, dbound_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign sample_ready = state_q == S_IDLE;
	assign result_valid = rv_q;
	assign drive = drive_q;
	assign saturated = sat_q;

	// front end
	assign err = {target[31], target} - {measured[31], measured};
	assign diff = {err[32], err} - {le_q[32], le_q};
	assign diff_mag = diff[33] ? 33'(-diff) : diff[32:0];
	assign dt_cap = (step_us > MAX_STEP_US) ? MAX_STEP_US : step_us;
	assign e_mag = e_q[32] ? 33'(-e_q) : e_q;
	assign e_pos = !e_q[32] && (e_q != '0);

	assign gp_mag = gain_p_q[31] ? 32'(-gain_p_q) : gain_p_q;
	assign gi_mag = gain_i_q[31] ? 32'(-gain_i_q) : gain_i_q;
	assign gd_mag = gain_d_q[31] ? 32'(-gain_d_q) : gain_d_q;
	assign d_mag = d_q[39] ? 40'(-d_q) : d_q;
	assign cand_mag = cand_q[31] ? 32'(-cand_q) : cand_q;
	assign ia_mag = ia_q[31] ? 32'(-ia_q) : ia_q;

	// serial multiplier
	assign mul_add = hi_q + (ma_q[0] ? {1'b0, mb_q} : 41'd0);
	assign prod = {1'b0, mul_add[40:1], mul_add[0], ma_q[31:1]};
	assign term_mag = prod[71:16];
	assign term = sg_q ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});

	// serial divider
	assign trial = {rem_q, dq_q[53]} - {1'b0, dv_q};
	assign ge = !trial[20];
	assign rem_n = ge ? trial[19:0] : {rem_q[18:0], dq_q[53]};
	assign quo = {dq_q[52:0], ge};

	always_comb begin
		if (!sg_q) begin
			raw = (|quo[53:39]) ? DERIV_MAX : $signed({1'b0, quo[38:0]});
		end else begin
			raw = ((|quo[53:40]) || (quo[39] && (|quo[38:0]))) ? DERIV_MIN
				: 40'(-$signed({1'b0, quo[39:0]}));
		end
	end
	assign flt_x = {raw[39], raw} - {d_q[39], d_q};
	assign flt_y = {flt_x[40], flt_x[40], flt_x} + {flt_x[40], flt_x, 1'b0};
	assign flt_mag = flt_y[42] ? 42'(-flt_y) : flt_y[41:0];
	assign flt_step = sg_q ? 40'(-$signed({1'b0, quo[38:0]})) : $signed({1'b0, quo[38:0]});

	assign incr = sg_q ? -$signed({1'b0, quo[28:0]}) : $signed({1'b0, quo[28:0]});
	assign csum = {ia_q[31], ia_q[31], ia_q} + {{4{incr[29]}}, incr};
	assign ib_ext = $signed({3'b000, ibound_q});
	always_comb begin
		priority if (csum > ib_ext) cand = $signed({1'b0, ibound_q});
		else if (csum < -ib_ext)    cand = 32'(-ib_ext);
		else                        cand = csum[31:0];
	end

	assign db_ext = $signed({27'd0, dbound_q});
	assign sc = spd_q + term;
	assign accept = (sc < db_ext && sc > -db_ext) || (sc >= db_ext && e_q[32])
		|| (sc <= -db_ext && e_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			primed_q <= 1'b0;
			rv_q     <= 1'b0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			ibound_q <= '0;
			dbound_q <= '0;
			ia_q     <= '0;
			le_q     <= '0;
			d_q      <= '0;
		end else begin
			if (rv_q && result_ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						e_q    <= err;
						dt_q   <= dt_cap;
						cnt_q  <= '0;
						hi_q   <= '0;
						rem_q  <= '0;
						if (step_us == 16'd0) begin
							sum_q   <= '0;
							state_q <= S_OUT;
						end else begin
							le_q <= err;
							if (primed_q) begin
								ma_q    <= {12'd0, USEC_PER_S};
								mb_q    <= {7'd0, diff_mag};
								sg_q    <= diff[33];
								state_q <= S_DMUL;
							end else begin
								primed_q <= 1'b1;
								d_q      <= '0;
								ma_q     <= {16'd0, dt_cap};
								mb_q     <= {7'd0, (err[32] ? 33'(-err) : err)};
								sg_q     <= err[32];
								state_q  <= S_IMUL;
							end
						end
					end
				end
				S_DMUL, S_IMUL, S_PMUL, S_GMUL, S_CMUL, S_OMUL: begin
					hi_q  <= {1'b0, mul_add[40:1]};
					ma_q  <= {mul_add[0], ma_q[31:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						hi_q  <= '0;
						rem_q <= '0;
						unique case (state_q)
							S_DMUL: begin
								dq_q    <= prod[53:0];
								dv_q    <= {4'd0, dt_q};
								state_q <= S_RDIV;
							end
							S_IMUL: begin
								dq_q    <= prod[53:0];
								dv_q    <= USEC_PER_S;
								state_q <= S_IDIV;
							end
							S_PMUL: begin
								spd_q   <= term;
								ma_q    <= gd_mag;
								mb_q    <= d_mag;
								sg_q    <= gain_d_q[31] ^ d_q[39];
								state_q <= S_GMUL;
							end
							S_GMUL: begin
								spd_q   <= spd_q + term;
								ma_q    <= gi_mag;
								mb_q    <= {8'd0, cand_mag};
								sg_q    <= gain_i_q[31] ^ cand_q[31];
								state_q <= S_CMUL;
							end
							S_CMUL: begin
								if (accept) begin
									ia_q    <= cand_q;
									sum_q   <= sc;
									state_q <= S_OUT;
								end else begin
									ma_q    <= gi_mag;
									mb_q    <= {8'd0, ia_mag};
									sg_q    <= gain_i_q[31] ^ ia_q[31];
									state_q <= S_OMUL;
								end
							end
							default: begin
								sum_q   <= sc;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RDIV, S_FDIV, S_IDIV: begin
					rem_q <= rem_n;
					dq_q  <= quo;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						rem_q <= '0;
						hi_q  <= '0;
						unique case (state_q)
							S_RDIV: begin
								dq_q    <= {12'd0, flt_mag};
								dv_q    <= FILT_DEN;
								sg_q    <= flt_y[42];
								state_q <= S_FDIV;
							end
							S_FDIV: begin
								d_q     <= d_q + flt_step;
								ma_q    <= {16'd0, dt_q};
								mb_q    <= {7'd0, e_mag};
								sg_q    <= e_q[32];
								state_q <= S_IMUL;
							end
							default: begin
								cand_q  <= cand;
								ma_q    <= gp_mag;
								mb_q    <= {7'd0, e_mag};
								sg_q    <= gain_p_q[31] ^ e_q[32];
								state_q <= S_PMUL;
							end
						endcase
					end
				end
				S_OUT: begin
					if (!rv_q || result_ready) begin
						rv_q <= 1'b1;
						priority if (sum_q > db_ext) begin
							drive_q <= $signed({1'b0, dbound_q});
							sat_q   <= 1'b1;
						end else if (sum_q < -db_ext) begin
							drive_q <= 32'(-db_ext);
							sat_q   <= 1'b1;
						end else begin
							drive_q <= sum_q[31:0];
							sat_q   <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr && cfg_hit) begin
				unique case (cfg_idx)
					REG_GAIN_P:         gain_p_q <= pwdata;
					REG_GAIN_I:         gain_i_q <= pwdata;
					REG_GAIN_D:         gain_d_q <= pwdata;
					REG_INTEGRAL_BOUND: ibound_q <= pwdata[30:0];
					default:            dbound_q <= pwdata[30:0];
				endcase
				ia_q     <= '0;
				le_q     <= '0;
				d_q      <= '0;
				primed_q <= 1'b0;
			end
		end
	end

	a_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && step_us == 16'd0 |=> state_q == S_OUT)
		else $error("zero step did not go straight to output");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIV_LAST)
		else $error("step counter out of range");

	a_primed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(primed_q) |-> $past(cfg_wr && cfg_hit))
		else $error("filter state cleared without register write");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && rv_q && !result_ready |=> state_q == S_OUT)
		else $error("pending word overwritten");

endmodule

// ===== tb/sv/pid_filtered_derivative_antiwindup_checker.sv =====
module pid_filtered_derivative_antiwindup_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measured,
	input  logic [15:0] step_us,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic signed [31:0] drive,
	input  logic        saturated,
	output int          fail_count,
	output int          pending,
	output int          drive_count,
	output int          sat_count
);
	import pidfd_pkg::*;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               saturated;
	} drive_word_t;

	longint kp, ki, kd, ilim, dlim;
	longint integ, prev_err, dfilt;
	bit     primed;
	drive_word_t drive_q[$];

	function automatic longint q16_product(longint a, longint b);
		bit neg;
		longint ua, ub, r;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		r = ua * (ub >>> 16) + ((ua * (ub & 64'hFFFF)) >>> 16);
		return neg ? -r : r;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic drive_word_t predict_word(longint sp, longint pv, longint st);
		drive_word_t w;
		longint err, dt, raw, cand, sum, d;
		bit keep;
		err = sp - pv;
		dt = st;
		w = '0;
		if (dt == 0) return w;
		if (dt > MAX_STEP_US) dt = MAX_STEP_US;
		if (primed) begin
			raw = (err - prev_err) * 1000000 / dt;
			if (raw > DERIV_MAX) raw = DERIV_MAX;
			if (raw < DERIV_MIN) raw = DERIV_MIN;
			dfilt = dfilt + (raw - dfilt) * 3 / 10;
		end else begin
			primed = 1;
			dfilt = 0;
		end
		cand = clamp_mag(integ + err * dt / 1000000, ilim);
		sum = q16_product(kp, err) + q16_product(ki, cand) + q16_product(kd, dfilt);
		keep = (sum < dlim && sum > -dlim) || (sum >= dlim && err < 0) ||
			(sum <= -dlim && err > 0);
		if (keep) integ = cand;
		sum = q16_product(kp, err) + q16_product(ki, integ) + q16_product(kd, dfilt);
		prev_err = err;
		d = clamp_mag(sum, dlim);
		w.drive = d[31:0];
		w.saturated = d != sum;
		return w;
	endfunction

	assign pending = drive_q.size();

	always @(posedge clk or negedge arst_n) begin
		drive_word_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			kp = 0; ki = 0; kd = 0; ilim = 0; dlim = 0;
			integ = 0; prev_err = 0; dfilt = 0; primed = 0;
			drive_q.delete();
			fail_count <= 0;
			drive_count <= 0;
			sat_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_GAIN_P: kp = longint'($signed(pwdata));
					REG_GAIN_I: ki = longint'($signed(pwdata));
					REG_GAIN_D: kd = longint'($signed(pwdata));
					REG_INTEGRAL_BOUND: ilim = longint'(pwdata[30:0]);
					REG_DRIVE_BOUND: dlim = longint'(pwdata[30:0]);
					default: ;
				endcase
				if (paddr[4:2] <= REG_DRIVE_BOUND) begin
					integ = 0; prev_err = 0; dfilt = 0; primed = 0;
				end
			end
			if (sample_valid && sample_ready)
				drive_q.push_back(predict_word(longint'(target), longint'(measured),
					longint'(step_us)));
			if (result_valid && result_ready) begin
				drive_count <= drive_count + 1;
				if (saturated) sat_count <= sat_count + 1;
				if (drive_q.size() == 0) begin
					$error("unexpected word: drive %0d saturated %0d", drive, saturated);
					errs++;
				end else begin
					e = drive_q.pop_front();
					if (e.drive !== drive) begin
						$error("drive: expected %0d, got %0d", e.drive, drive);
						errs++;
					end
					if (e.saturated !== saturated) begin
						$error("saturated: expected %0d, got %0d", e.saturated, saturated);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== tb/sv/tb_pid_filtered_derivative_antiwindup_unit.sv =====
module tb_pid_filtered_derivative_antiwindup_unit;
	import pidfd_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic sample_valid = 0, sample_ready;
	logic signed [31:0] target = '0, measured = '0;
	logic [15:0] step_us = '0;
	logic result_valid, result_ready = 0;
	logic signed [31:0] drive;
	logic saturated;
	int fail_count, pending, drive_count, sat_count;
	int idle_cycles = 0, sent = 0;
	bit hold_off = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	pid_filtered_derivative_antiwindup_unit uut (.*);

	pid_filtered_derivative_antiwindup_checker checker_i (.*);

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	// receiver: random stalls plus one long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				result_ready <= 0;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0) begin
				result_ready <= 0;
				repeat (g) @(posedge clk);
			end
			result_ready <= 1;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_word(logic [31:0] sp, logic [31:0] pv, logic [15:0] st);
		int g;
		g = gap_len();
		if (sent % 40 == 0) g = 0;
		if (g > 0) begin
			sample_valid <= 0;
			repeat (g) @(posedge clk);
		end
		sample_valid <= 1; target <= sp; measured <= pv; step_us <= st;
		do @(posedge clk); while (!(sample_valid && sample_ready));
		sent++;
	endtask

	task automatic drain();
		sample_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic setup(logic [31:0] p, logic [31:0] i, logic [31:0] d,
		logic [31:0] ib, logic [31:0] db);
		drain();
		reg_write(REG_GAIN_P, p);
		reg_write(REG_GAIN_I, i);
		reg_write(REG_GAIN_D, d);
		reg_write(REG_INTEGRAL_BOUND, ib);
		reg_write(REG_DRIVE_BOUND, db);
	endtask

	function automatic logic [31:0] rand_val(int sz);
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(0, 5))
			0: return v;
			1: return {1'b0, v[30:0]};
			2: return {1'b1, v[30:0]};
			default: return {{(32 - 22){v[21]}}, v[21:0]} >>> sz;
		endcase
	endfunction

	function automatic logic [15:0] rand_step();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'($urandom());
		if (r == 2) return 16'(MAX_STEP_US + $urandom_range(0, 3));
		return 16'($urandom_range(1, 20000));
	endfunction

	initial begin
		logic [31:0] sp;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		setup(32'h0001_8000, 32'h0000_4000, 32'h0000_0100, 32'h0010_0000, 32'h0040_0000);
		send_word(32'h0001_0000, 32'h0, 16'd1000);
		send_word(32'h0001_0000, 32'h0, 16'd0);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 16'd20000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		send_word(32'h0000_0000, 32'h0000_0000, 16'd20001);
		send_word(32'hFFFF_FFFF, 32'h0000_0001, 16'd1);
		setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		send_word(32'h1234_5678, 32'h8765_4321, 16'd500);
		setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_word(32'h0, 32'h0, 16'd100);
		send_word(32'h0001_0000, 32'h0, 16'd100);
		send_word(32'h0, 32'h0001_0000, 16'd100);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		setup(32'h0002_0000, 32'h0010_0000, 32'h0000_0010, 32'h0000_8000, 32'h0000_4000);
		send_word(32'h0000_1000, 32'h0, 16'd20000);
		send_word(32'h0000_1000, 32'h0, 16'd20000);
		send_word(32'hFFFF_0000, 32'h0, 16'd20000);
		send_word(32'hFFFF_0000, 32'h0, 16'd20000);
		for (int k = 0; k < 1800; k++) begin
			if (k % 150 == 0)
				setup(rand_val(k % 5), rand_val(k % 7), rand_val(8), rand_val(2),
					rand_val(4));
			if (k == 10) hold_off = 1;
			sp = rand_val($urandom_range(0, 10));
			if ($urandom_range(0, 3) != 0)
				send_word(sp, sp - (rand_val(8) >>> 6), rand_step());
			else
				send_word(sp, rand_val($urandom_range(0, 10)), rand_step());
		end
		drain();
		$display("sent %0d samples, got %0d drive words, %0d saturated", sent,
			drive_count, sat_count);
		$display("register settings included zero, full-scale and random gains and bounds");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== sim.f =====
src/pidfd_pkg.sv
src/pid_filtered_derivative_antiwindup_unit.sv
tb/sv/pid_filtered_derivative_antiwindup_checker.sv
tb/sv/tb_pid_filtered_derivative_antiwindup_unit.sv
